/* design/lrtf_pkg.sv */
// shared types and constants of the learning route table forwarder
package lrtf_pkg;

  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
  localparam logic [63:0] FLOOD_HOP      = 64'h0000_0000_0000_FFFF;

  localparam logic [1:0] IF_SELF = 2'd0;
  localparam logic [1:0] IF_BUS  = 2'd1;
  localparam logic [1:0] IF_LINK = 2'd2;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDRESS  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINK_PRESENT = 8'd1;

  localparam logic [15:0] OWN_ADDRESS_RESET = 16'd1;

  typedef struct packed {
    logic [15:0] dest;
    logic [1:0]  port;
    logic [63:0] hop;
  } lrtf_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } lrtf_state_e;

  typedef struct packed {
    logic clear;
    logic cmp_en;
  } lrtf_scan_ctl_t;

  typedef struct packed {
    logic from_hit;
    logic to_hit;
  } lrtf_hit_t;

endpackage

/* design/lrtf_ram.sv */
// generic single write, single read ram with registered read data
module lrtf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lrtf_rank.sv */
// recency rank cells, aged in parallel on each learn
module lrtf_rank #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]  used_i,
  input  logic                                upd_en_i,
  input  logic [$clog2(TABLE_ENTRIES):0]      limit_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]    slot_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]    rd_idx_i,
  output logic [$clog2(TABLE_ENTRIES)-1:0]    rd_rank_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);

  logic [IW-1:0] rank_q [TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic valid;
    logic older;
    assign valid = UW'(g) < used_i;
    assign older = {1'b0, rank_q[g]} < limit_i;

    always_ff @(posedge clk_i) begin
      if (upd_en_i) begin
        if (slot_i == IW'(g)) begin
          rank_q[g] <= '0;
        end else if (valid && older) begin
          rank_q[g] <= rank_q[g] + IW'(1);
        end
      end
    end
  end

  assign rd_rank_o = rank_q[rd_idx_i];

endmodule

/* design/lrtf_scan.sv */
// compare unit shared over all table slots, captures hits and eviction candidate
module lrtf_scan
  import lrtf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lrtf_scan_ctl_t                   ctl_i,
  input  lrtf_entry_t                      entry_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] rank_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] idx_i,
  input  logic [15:0]                      from_addr_i,
  input  logic [15:0]                      to_addr_i,
  output lrtf_hit_t                        hit_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] from_slot_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] from_rank_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] to_slot_o,
  output logic [1:0]                       to_port_o,
  output logic [63:0]                      to_hop_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] evict_slot_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  lrtf_hit_t     hit_q;
  logic [IW-1:0] from_slot_q, from_rank_q, to_slot_q, evict_slot_q;
  logic [1:0]    to_port_q;
  logic [63:0]   to_hop_q;

  logic from_match, to_match, oldest;

  assign from_match = ctl_i.cmp_en && !hit_q.from_hit && (entry_i.dest == from_addr_i);
  assign to_match   = ctl_i.cmp_en && !hit_q.to_hit && (entry_i.dest == to_addr_i);
  assign oldest     = ctl_i.cmp_en && (rank_i == IW'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else if (ctl_i.clear) begin
      hit_q <= '0;
    end else begin
      if (from_match) hit_q.from_hit <= 1'b1;
      if (to_match)   hit_q.to_hit   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      evict_slot_q <= '0;
    end else if (oldest) begin
      evict_slot_q <= idx_i;
    end
    if (from_match) begin
      from_slot_q <= idx_i;
      from_rank_q <= rank_i;
    end
    if (to_match) begin
      to_slot_q <= idx_i;
      to_port_q <= entry_i.port;
      to_hop_q  <= entry_i.hop;
    end
  end

  assign hit_o        = hit_q;
  assign from_slot_o  = from_slot_q;
  assign from_rank_o  = from_rank_q;
  assign to_slot_o    = to_slot_q;
  assign to_port_o    = to_port_q;
  assign to_hop_o     = to_hop_q;
  assign evict_slot_o = evict_slot_q;

endmodule

/* design/learning_route_table_forwarder_core.sv */
// learning route table forwarder: sequencer, config registers and result logic
//
// usage: a packet header request is taken at a rising edge with start high
// and busy low. the block then walks the valid table slots one per cycle
// through a single compare unit, looking for the source and destination
// addresses and the oldest slot at the same time. a drain state and the
// update state follow; the update applies the learn for a source port other
// than self (table write, parallel rank aging) and registers the answer.
// the wait from accept to result strobe grows with the used slots; with an
// empty table the scan and drain are skipped. busy is high all that time and a
// new request may be taken in the cycle the result is shown.
// the result stands on the result ports for one cycle with result_valid_o
// high; the receiver cannot stall it.
// config writes (own_address at index 0, link_present at index 1) are
// taken every cycle on cfg_valid_i; cfg_ready_o is always high.
// reset empties the table (slot count zero), own_address = 1,
// link_present = 1; no clearing pass is needed.
module learning_route_table_forwarder_core
  import lrtf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         from_addr_i,
  input  logic [15:0]         to_addr_i,
  input  logic [1:0]          source_port_i,
  input  logic [63:0]         source_link_addr_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                result_valid_o,
  output logic                deliver_local_o,
  output logic                send_bus_o,
  output logic                send_link_o,
  output logic                route_known_o,
  output logic [63:0]         next_hop_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW = $bits(lrtf_entry_t);

  lrtf_state_e state_q, state_d;

  logic [15:0] own_q;
  logic        link_q;
  logic [UW-1:0] used_q;
  logic [IW-1:0] idx_q, cmp_idx_q;
  logic          cmp_vld_q;

  logic [15:0] from_q, to_q;
  logic [1:0]  src_q;
  logic [63:0] hop_q;

  logic        res_vld_q, local_q, bus_q, link_out_q, known_q;
  logic [63:0] next_hop_q;

  logic accept, last_idx, full, learn;
  logic ram_re, upd_en;
  lrtf_scan_ctl_t scan_ctl;

  lrtf_entry_t   rd_entry, wr_entry;
  logic [IW-1:0] rd_rank;
  lrtf_hit_t     hit;
  logic [IW-1:0] from_slot, from_rank, to_slot, evict_slot;
  logic [1:0]    to_port;
  logic [63:0]   to_hop;

  logic [IW-1:0] slot;
  logic [IW:0]   limit;

  assign accept   = start && !busy;
  assign busy     = state_q != ST_IDLE;
  assign last_idx = (UW'(idx_q) + UW'(1)) == used_q;
  assign full     = used_q == UW'(TABLE_ENTRIES);
  assign learn    = src_q != IF_SELF;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (used_q == '0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_idx) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_re          = 1'b0;
    upd_en          = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.cmp_en = cmp_vld_q;
    case (state_q)
      ST_IDLE:   scan_ctl.clear = accept;
      ST_SCAN:   ram_re = 1'b1;
      ST_DRAIN:  ;
      ST_UPDATE: upd_en = learn;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      used_q    <= '0;
      own_q     <= OWN_ADDRESS_RESET;
      link_q    <= 1'b1;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= ram_re;
      if (accept) begin
        idx_q <= '0;
      end else if (ram_re) begin
        idx_q <= idx_q + IW'(1);
      end
      if (upd_en && !hit.from_hit && !full) begin
        used_q <= used_q + UW'(1);
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_OWN_ADDRESS)  own_q  <= cfg_data_i;
        if (cfg_index_i == CFG_LINK_PRESENT) link_q <= cfg_data_i[0];
      end
      res_vld_q <= state_q == ST_UPDATE;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (accept) begin
      from_q <= from_addr_i;
      to_q   <= to_addr_i;
      src_q  <= source_port_i;
      hop_q  <= source_link_addr_i;
    end
  end

  // slot to learn into and aging limit
  always_comb begin
    if (hit.from_hit) begin
      slot  = from_slot;
      limit = {1'b0, from_rank};
    end else if (!full) begin
      slot  = used_q[IW-1:0];
      limit = (IW+1)'(TABLE_ENTRIES);
    end else begin
      slot  = evict_slot;
      limit = (IW+1)'(TABLE_ENTRIES - 1);
    end
  end

  assign wr_entry.dest = from_q;
  assign wr_entry.port = src_q;
  assign wr_entry.hop  = hop_q;

  lrtf_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (upd_en),
    .waddr_i (slot),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  lrtf_rank #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_rank (
    .clk_i     (clk_i),
    .used_i    (used_q),
    .upd_en_i  (upd_en),
    .limit_i   (limit),
    .slot_i    (slot),
    .rd_idx_i  (cmp_idx_q),
    .rd_rank_o (rd_rank)
  );

  lrtf_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .entry_i      (rd_entry),
    .rank_i       (rd_rank),
    .idx_i        (cmp_idx_q),
    .from_addr_i  (from_q),
    .to_addr_i    (to_q),
    .hit_o        (hit),
    .from_slot_o  (from_slot),
    .from_rank_o  (from_rank),
    .to_slot_o    (to_slot),
    .to_port_o    (to_port),
    .to_hop_o     (to_hop),
    .evict_slot_o (evict_slot)
  );

  // destination as seen after this learn
  logic        found;
  logic [1:0]  fport;
  logic [63:0] fhop;
  logic        loc_d, bus_d, link_d, known_d;
  logic [63:0] nhop_d;

  always_comb begin
    found = hit.to_hit;
    fport = to_port;
    fhop  = to_hop;
    if (learn && (to_q == from_q)) begin
      found = 1'b1;
      fport = src_q;
      fhop  = hop_q;
    end else if (learn && !hit.from_hit && full && hit.to_hit && (to_slot == evict_slot)) begin
      // destination entry is the one being evicted
      found = 1'b0;
    end
  end

  always_comb begin
    loc_d   = 1'b0;
    bus_d   = 1'b0;
    link_d  = 1'b0;
    known_d = 1'b0;
    nhop_d  = '0;
    if (to_q == own_q) begin
      loc_d = 1'b1;
    end else begin
      loc_d = to_q == BROADCAST_ADDR;
      if (found && (to_q != BROADCAST_ADDR)) begin
        known_d = 1'b1;
        nhop_d  = fhop;
        bus_d   = (fport == IF_BUS) && (src_q != IF_BUS);
        link_d  = (fport == IF_LINK) && link_q && (src_q != IF_LINK);
      end else begin
        nhop_d = FLOOD_HOP;
        bus_d  = src_q != IF_BUS;
        link_d = link_q && (src_q != IF_LINK);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      local_q    <= loc_d;
      bus_q      <= bus_d;
      link_out_q <= link_d;
      known_q    <= known_d;
      next_hop_q <= nhop_d;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign result_valid_o  = res_vld_q;
  assign deliver_local_o = local_q;
  assign send_bus_o      = bus_q;
  assign send_link_o     = link_out_q;
  assign route_known_o   = known_q;
  assign next_hop_o      = next_hop_q;

endmodule

/* dv/tb_top.sv */
// testbench for the learning route table forwarder core
`timescale 1ns / 1ps

module tb_top;
  import lrtf_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
  localparam int unsigned POOL_MAX = 40;
  localparam logic [1:0] IF_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] from_addr;
    logic [15:0] to_addr;
    logic [1:0]  port;
    logic [63:0] hop;
  } header_t;

  typedef struct packed {
    logic        deliver;
    logic        to_bus;
    logic        to_link;
    logic        known;
    logic [63:0] hop;
  } decision_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [15:0]         from_addr_i;
  logic [15:0]         to_addr_i;
  logic [1:0]          source_port_i;
  logic [63:0]         source_link_addr_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                result_valid_o;
  logic                deliver_local_o;
  logic                send_bus_o;
  logic                send_link_o;
  logic                route_known_o;
  logic [63:0]         next_hop_o;

  learning_route_table_forwarder_core #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .from_addr_i       (from_addr_i),
    .to_addr_i         (to_addr_i),
    .source_port_i     (source_port_i),
    .source_link_addr_i(source_link_addr_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .deliver_local_o   (deliver_local_o),
    .send_bus_o        (send_bus_o),
    .send_link_o       (send_link_o),
    .route_known_o     (route_known_o),
    .next_hop_o        (next_hop_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of config and route table
  logic [15:0] own_addr_q;
  logic        link_on_q;
  int unsigned slots_used;
  logic [15:0] slot_dest [ENTRIES];
  logic [1:0]  slot_port [ENTRIES];
  logic [63:0] slot_hop  [ENTRIES];
  int unsigned slot_rank [ENTRIES];

  decision_t   pending_routes[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 17;
  int unsigned pool_size = 1;
  logic [15:0] addr_pool [POOL_MAX];

  function automatic int find_slot_of(logic [15:0] addr);
    for (int i = 0; i < int'(slots_used); i++) begin
      if (slot_dest[i] == addr) return i;
    end
    return -1;
  endfunction

  // every valid slot younger than limit gets one step older
  function automatic void age_slots(int unsigned limit);
    for (int unsigned i = 0; i < slots_used; i++) begin
      if (slot_rank[i] < limit) slot_rank[i]++;
    end
  endfunction

  function automatic void learn_source(logic [15:0] addr, logic [1:0] port,
                                       logic [63:0] hop);
    int hit;
    int unsigned slot;
    hit = find_slot_of(addr);
    if (hit >= 0) begin
      slot = hit;
      age_slots(slot_rank[slot]);
    end else if (slots_used < ENTRIES) begin
      slot = slots_used;
      age_slots(ENTRIES);
      slots_used++;
    end else begin
      // table full: replace the oldest entry
      slot = 0;
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (slot_rank[i] == ENTRIES - 1) slot = i;
      end
      age_slots(ENTRIES - 1);
    end
    slot_dest[slot] = addr;
    slot_port[slot] = port;
    slot_hop[slot]  = hop;
    slot_rank[slot] = 0;
  endfunction

  function automatic decision_t forward_decision(header_t h);
    decision_t d;
    int hit;
    d = '0;
    if (h.port != IF_SELF) learn_source(h.from_addr, h.port, h.hop);
    if (h.to_addr == own_addr_q) begin
      d.deliver = 1'b1;
    end else begin
      hit = (h.to_addr == BROADCAST_ADDR) ? -1 : find_slot_of(h.to_addr);
      if (h.to_addr == BROADCAST_ADDR) d.deliver = 1'b1;
      if (hit >= 0) begin
        d.known = 1'b1;
        d.hop   = slot_hop[hit];
        if (slot_port[hit] == IF_BUS && h.port != IF_BUS) begin
          d.to_bus = 1'b1;
        end else if (slot_port[hit] == IF_LINK && link_on_q && h.port != IF_LINK) begin
          d.to_link = 1'b1;
        end
      end else begin
        d.hop     = FLOOD_HOP;
        d.to_bus  = (h.port != IF_BUS);
        d.to_link = link_on_q && (h.port != IF_LINK);
      end
    end
    return d;
  endfunction

  function automatic header_t hdr(logic [15:0] from_a, logic [15:0] to_a,
                                  logic [1:0] port, logic [63:0] hop);
    header_t h;
    h.from_addr = from_a;
    h.to_addr   = to_a;
    h.port      = port;
    h.hop       = hop;
    return h;
  endfunction

  function automatic header_t random_header();
    header_t h;
    int unsigned pick;
    pick = $urandom_range(99);
    h.from_addr = (pick < 85) ? addr_pool[$urandom_range(pool_size - 1)] : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 50)      h.to_addr = addr_pool[$urandom_range(pool_size - 1)];
    else if (pick < 62) h.to_addr = BROADCAST_ADDR;
    else if (pick < 72) h.to_addr = own_addr_q;
    else                h.to_addr = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 15)      h.port = IF_SELF;
    else if (pick < 55) h.port = IF_BUS;
    else if (pick < 95) h.port = IF_LINK;
    else                h.port = IF_UNUSED;
    h.hop = {$urandom(), $urandom()};
    return h;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // start stays high between back-to-back requests unless an idle gap is drawn
  task automatic send_header(input header_t h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start              <= 1'b1;
    from_addr_i        <= h.from_addr;
    to_addr_i          <= h.to_addr;
    source_port_i      <= h.port;
    source_link_addr_i <= h.hop;
    do @(posedge clk_i); while (busy);
    pending_routes.push_back(forward_decision(h));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_OWN_ADDRESS) own_addr_q = data;
    else if (idx == CFG_LINK_PRESENT) link_on_q = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_header(hdr(16'h0000, OWN_ADDRESS_RESET, IF_SELF, 64'h0));
    send_header(hdr(16'h1234, BROADCAST_ADDR, IF_SELF, {$urandom(), $urandom()}));
    send_header(hdr(16'hFFFF, 16'h2222, IF_LINK, '1));
  endtask

  task automatic test_learned_routes();
    send_header(hdr(16'h0A01, 16'h0000, IF_BUS, {$urandom(), $urandom()}));
    send_header(hdr(16'h0B02, 16'h0A01, IF_LINK, {$urandom(), $urandom()}));
    // route back to the arriving port is dropped
    send_header(hdr(16'h0C03, 16'h0A01, IF_BUS, 64'h0));
    send_header(hdr(16'h0D04, 16'h0B02, IF_BUS, '1));
    send_header(hdr(16'h0E05, 16'h0B02, IF_LINK, {$urandom(), $urandom()}));
    send_header(hdr(16'h0F06, 16'h0E05, IF_UNUSED, {$urandom(), $urandom()}));
    // route learned on the unused port value drops
    send_header(hdr(16'h0A01, 16'h0F06, IF_BUS, {$urandom(), $urandom()}));
    send_header(hdr(16'h5A5A, BROADCAST_ADDR, IF_UNUSED, {$urandom(), $urandom()}));
    send_header(hdr(16'h0000, 16'h0C03, IF_SELF, {$urandom(), $urandom()}));
  endtask

  task automatic test_link_absent();
    write_reg(CFG_LINK_PRESENT, 16'd0);
    send_header(hdr(16'h0D04, 16'h0B02, IF_BUS, {$urandom(), $urandom()}));
    send_header(hdr(16'h0D04, 16'h7777, IF_SELF, {$urandom(), $urandom()}));
    send_header(hdr(16'h0A01, BROADCAST_ADDR, IF_BUS, {$urandom(), $urandom()}));
    write_reg(CFG_LINK_PRESENT, 16'd1);
  endtask

  task automatic test_own_address();
    // own address of all ones turns broadcast into local delivery only
    write_reg(CFG_OWN_ADDRESS, 16'hFFFF);
    send_header(hdr(16'h0C03, BROADCAST_ADDR, IF_BUS, {$urandom(), $urandom()}));
    write_reg(CFG_OWN_ADDRESS, 16'h0000);
    send_header(hdr(16'h0B02, 16'h0000, IF_LINK, {$urandom(), $urandom()}));
    write_reg(CFG_OWN_ADDRESS, 16'hFFFE);
    send_header(hdr(16'h0A01, 16'hFFFE, IF_BUS, {$urandom(), $urandom()}));
  endtask

  task automatic run_phase(input logic [15:0] own, input logic link,
                           input int unsigned pool_n, input int unsigned idle,
                           input int unsigned count);
    write_reg(CFG_OWN_ADDRESS, own);
    write_reg(CFG_LINK_PRESENT, {{(CfgDataW-1){1'b0}}, link});
    pool_size = pool_n;
    idle_pct  = idle;
    repeat (count) send_header(random_header());
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < POOL_MAX; i++) addr_pool[i] = 16'($urandom);
    addr_pool[3] = 16'h0000;
    addr_pool[7] = 16'hFFFF;
    // small pools keep hit rates high, large pools force evictions
    run_phase(16'h0001, 1'b1, 12, 17, 350);
    run_phase(16'h0000, 1'b0, 24, 17, 350);
    run_phase(16'hFFFE, 1'b1, 24, 0, 350);
    run_phase(16'hFFFF, 1'b0, 40, 17, 350);
    run_phase(16'($urandom_range(65534)), 1'b1, 20, 17, 350);
  endtask

  always @(posedge clk_i) begin : check_results
    decision_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("result with no request pending", next_hop_o, 64'h0);
      end else begin
        want = pending_routes.pop_front();
        if (deliver_local_o !== want.deliver)
          report_mismatch("deliver_local", 64'(deliver_local_o), 64'(want.deliver));
        if (send_bus_o !== want.to_bus)
          report_mismatch("send_bus", 64'(send_bus_o), 64'(want.to_bus));
        if (send_link_o !== want.to_link)
          report_mismatch("send_link", 64'(send_link_o), 64'(want.to_link));
        if (route_known_o !== want.known)
          report_mismatch("route_known", 64'(route_known_o), 64'(want.known));
        if (next_hop_o !== want.hop)
          report_mismatch("next_hop", next_hop_o, want.hop);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    start              = 1'b0;
    from_addr_i        = '0;
    to_addr_i          = '0;
    source_port_i      = IF_SELF;
    source_link_addr_i = '0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = CFG_OWN_ADDRESS;
    cfg_data_i         = '0;
    own_addr_q         = OWN_ADDRESS_RESET;
    link_on_q          = 1'b1;
    slots_used         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_learned_routes();
    test_link_absent();
    test_own_address();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
